// ===== rtl/stes_pkg.sv =====
// ----------------------------------------------------------------------------
// stes_pkg
// Shared types and constants for the sorted table equal range search block:
// transaction kinds, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package stes_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_MAX_MATCHES = 64;

    localparam int KEY_W    = 32;
    localparam int OFFSET_W = 32;
    localparam int MATCH_W  = 33;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DOWN_RD,
        S_DOWN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_FINAL
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_table_equal_range_search_top.sv =====
// query: each binary search probe is a read then a compare state (about log2
// of the entry count probes), then each neighbor read in each scan direction
// (one memory read port), then the final transaction; back-pressure can stall scans
// input: clear and load finish in S_IDLE; one input transaction at a time
// reset: entry count, base offset and control clear at once; table contents
// are not cleared and only entries below the entry count are ever read
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search_top
// Holds (key, offset) pairs that the user must load in key order (not enforced),
// binary searches a key, reports up to MAX_MATCHES equal keys as base plus stored offset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_equal_range_search_top #(
    parameter int TABLE_DEPTH = stes_pkg::DEFAULT_TABLE_DEPTH,
    parameter int MAX_MATCHES = stes_pkg::DEFAULT_MAX_MATCHES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [stes_pkg::OFFSET_W-1:0]  base_offset,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     kind,
    input  wire logic [stes_pkg::KEY_W-1:0]     key,
    input  wire logic [stes_pkg::OFFSET_W-1:0]  entry_offset,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                found,
    output logic [stes_pkg::MATCH_W-1:0]        match_offset,
    output logic                                truncated,
    output logic                                last
);
    import stes_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int NW     = $clog2(MAX_MATCHES + 1);
    localparam int ENTRY_W = KEY_W + OFFSET_W;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      rd_addr;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       lo_reg, lo_next;
    logic [AW-1:0]       hi_reg, hi_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                trunc_reg, trunc_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [OFFSET_W-1:0] base_reg;
    logic                pend_found_reg, pend_found_next;
    logic [MATCH_W-1:0]  pend_off_reg, pend_off_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [MATCH_W-1:0]  out_off_reg, out_off_next;
    logic                out_trunc_reg, out_trunc_next;
    logic                out_last_reg, out_last_next;

    logic [KEY_W-1:0]    rd_key;
    logic [MATCH_W-1:0]  rd_match;
    logic [AW-1:0]       mid;
    logic                slot_free;
    logic                cap_hit;

    assign rd_key    = rd_data_reg[ENTRY_W-1:OFFSET_W];
    assign rd_match  = MATCH_W'(base_reg) + MATCH_W'(rd_data_reg[OFFSET_W-1:0]);
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign slot_free = !out_valid_reg || out_ready;
    assign cap_hit   = n_reg >= NW'(MAX_MATCHES);

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign match_offset = out_off_reg;
    assign truncated    = out_trunc_reg;
    assign last         = out_last_reg;

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[AW-1:0]] <= {key, entry_offset};
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= base_offset;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        trunc_reg      <= trunc_next;
        key_reg        <= key_next;
        pend_found_reg <= pend_found_next;
        pend_off_reg   <= pend_off_next;
        out_found_reg  <= out_found_next;
        out_off_reg    <= out_off_next;
        out_trunc_reg  <= out_trunc_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        trunc_next      = trunc_reg;
        key_next        = key_reg;
        pend_found_next = pend_found_reg;
        pend_off_next   = pend_off_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_found_next  = out_found_reg;
        out_off_next    = out_off_reg;
        out_trunc_next  = out_trunc_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        rd_addr         = mid;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind_t'(kind))
                        KIND_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        KIND_LOAD:
                        begin
                            if (cnt_reg < CW'(TABLE_DEPTH))
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        KIND_QUERY:
                        begin
                            key_next        = key;
                            trunc_next      = 1'b0;
                            pend_found_next = 1'b0;
                            pend_off_next   = '0;
                            lo_next         = '0;
                            hi_next         = AW'(cnt_reg - 1'b1);
                            state_next      = (cnt_reg == '0) ? S_FINAL : S_SRCH_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SRCH_RD:
            begin
                mem_re     = 1'b1;
                rd_addr    = mid;
                pos_next   = mid;
                state_next = S_SRCH_CMP;
            end

            S_SRCH_CMP:
            begin
                priority if (rd_key == key_reg)
                begin
                    pend_found_next = 1'b1;
                    pend_off_next   = rd_match;
                    n_next          = NW'(1);
                    idx_next        = CW'(pos_reg);
                    state_next      = S_DOWN_RD;
                end
                else if (lo_reg == hi_reg)
                begin
                    state_next = S_FINAL;
                end
                else if (rd_key > key_reg)
                begin
                    hi_next    = pos_reg;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    lo_next    = (lo_reg == pos_reg) ? pos_reg + 1'b1 : pos_reg;
                    state_next = S_SRCH_RD;
                end
            end

            S_DOWN_RD:
            begin
                if (idx_reg == '0)
                begin
                    idx_next   = CW'(pos_reg) + 1'b1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    rd_addr    = idx_reg[AW-1:0] - 1'b1;
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_DOWN_CMP;
                end
            end

            S_DOWN_CMP:
            begin
                priority if (rd_key != key_reg)
                begin
                    idx_next   = CW'(pos_reg) + 1'b1;
                    state_next = S_UP_RD;
                end
                else if (cap_hit)
                begin
                    trunc_next = 1'b1;
                    state_next = S_FINAL;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = pend_found_reg;
                    out_off_next   = pend_off_reg;
                    out_trunc_next = 1'b0;
                    out_last_next  = 1'b0;
                    pend_off_next  = rd_match;
                    n_next         = n_reg + 1'b1;
                    state_next     = S_DOWN_RD;
                end
                else
                begin
                end
            end

            S_UP_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    mem_re     = 1'b1;
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                priority if (rd_key != key_reg)
                begin
                    state_next = S_FINAL;
                end
                else if (cap_hit)
                begin
                    trunc_next = 1'b1;
                    state_next = S_FINAL;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = pend_found_reg;
                    out_off_next   = pend_off_reg;
                    out_trunc_next = 1'b0;
                    out_last_next  = 1'b0;
                    pend_off_next  = rd_match;
                    n_next         = n_reg + 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = S_UP_RD;
                end
                else
                begin
                end
            end

            S_FINAL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = pend_found_reg;
                    out_off_next   = pend_off_reg;
                    out_trunc_next = trunc_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table fill never passes capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // search window stays inside the valid entries
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH_CMP |-> lo_reg <= pos_reg && pos_reg <= hi_reg
            && CW'(hi_reg) < cnt_reg)
        else $error("search window outside valid entries");

    // result count never passes the cap during a scan
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOWN_CMP || state_reg == S_UP_CMP) |-> n_reg <= NW'(MAX_MATCHES)
            && n_reg != '0)
        else $error("match count outside range");

    // a miss is a single final transaction with zero offset
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last && !truncated && match_offset == '0)
        else $error("malformed miss transaction");

    // truncation only flagged on the final transaction of a hit
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> last && found)
        else $error("truncation flag on non final transaction");

endmodule

`default_nettype wire
